// ===== rtl/core/csee_pkg.sv =====
// Shared types, constants and helper functions for the C string escape expander.
`default_nettype none
package csee_pkg;

   localparam int unsigned MAX_LEN     = 4096;
   localparam int unsigned LEN_W       = $clog2(MAX_LEN + 1);
   localparam int unsigned TOTAL_LEN_W = 13;
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

   localparam logic [2:0] HEX_DIGITS = 3'd2;
   localparam logic [2:0] UNI_DIGITS = 3'd4;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_SEVEN  = 8'h37;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_X  = 8'h78;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;

   typedef logic [LEN_W-1:0] len_type;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_BSLASH,
      MODE_HEX,
      MODE_UNI,
      MODE_OCT
   } mode_type;

   typedef struct packed {
      logic                   ok;
      logic [3:0]             val;
   } hex_digit_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   is_end;
      logic [TOTAL_LEN_W-1:0] total_len;
      logic                   last;
   } rsp_item_type;

   // all results caused by one input word
   typedef struct packed {
      rsp_item_type [MAX_RESULTS-1:0] item;
      logic [CNT_W-1:0]               count;
   } res_set_type;

   function automatic hex_digit_type hex_digit(logic [7:0] b);
      hex_digit_type h;
      h.ok  = 1'b1;
      h.val = b[3:0];
      if (b >= CH_ZERO && b <= CH_NINE) begin
         h.val = b[3:0];
      end else if ((b >= CH_UP_A && b <= CH_UP_F) || (b >= CH_LOW_A && b <= CH_LOW_F)) begin
         h.val = 4'(b[3:0] + 4'd9);
      end else begin
         h.ok  = 1'b0;
         h.val = 4'd0;
      end
      return h;
   endfunction

   // control-character letters; other letters stand for themselves
   function automatic logic [7:0] letter_code(logic [7:0] b);
      logic [7:0] r;
      case (b)
         8'h61:   r = 8'h07;  // a
         8'h62:   r = 8'h08;  // b
         8'h65:   r = 8'h1B;  // e
         8'h66:   r = 8'h0C;  // f
         8'h6E:   r = 8'h0A;  // n
         8'h72:   r = 8'h0D;  // r
         8'h74:   r = 8'h09;  // t
         8'h76:   r = 8'h0B;  // v
         default: r = b;
      endcase
      return r;
   endfunction

   function automatic len_type sat_len(len_type len, logic [CNT_W-1:0] k);
      logic [LEN_W:0] sum;
      sum = {1'b0, len} + (LEN_W+1)'(k);
      if (sum >= (LEN_W+1)'(MAX_LEN)) begin
         return LEN_W'(MAX_LEN);
      end
      return sum[LEN_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/c_string_escape_expander_unit.sv =====
// Top level of the C string literal escape expander.
// Input channel req_: one raw literal-body byte per word, starting after the
// opening quote. Result channel rsp_: decoded bytes, an end marker (is_end,
// byte zero) when the closing quote arrives, the decoded length so far in
// total_len (saturating at MAX_LEN), and last on the final word of an input.
// An input word yields zero to four result words; bytes swallowed by an
// escape yield none. Decode is one combinational pass from the input port
// into the result register, so the first result appears the cycle after
// acceptance. A word with one result sustains one word per cycle while
// rsp_stall is low; a word with N results holds the input stalled while
// the result register drains them, one per cycle while rsp_stall is low.
// The next input is taken in the same cycle that the last pending result
// leaves. When rsp_stall is high the current result holds and req_stall
// stays high while any result is pending. Synchronous reset returns to
// normal (no escape pending), clears the length and drops pending results.
`default_nettype none
module c_string_escape_expander_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_end,
   output logic [12:0] rsp_total_len,
   output logic        rsp_last
);
   import csee_pkg::*;

   res_set_type  set;
   rsp_item_type item;
   logic         accept;

   assign accept = req_valid && !req_stall;

   csee_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .set     (set)
   );

   csee_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .set       (set),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_item  (item)
   );

   assign rsp_out_byte  = item.out_byte;
   assign rsp_is_end    = item.is_end;
   assign rsp_total_len = item.total_len;
   assign rsp_last      = item.last;

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_last)
      else $error("end marker not flagged last");

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_end |-> rsp_out_byte == 8'd0)
      else $error("end marker carries a data byte");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("result burst broken before last word");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken while results of earlier word pending");

endmodule
`default_nettype wire

// ===== rtl/core/csee_decode.sv =====
// Escape state and single-pass decode of one input word into up to four result words.
`default_nettype none
module csee_decode (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire  [7:0]            in_byte,
   output csee_pkg::res_set_type set
);
   import csee_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [15:0]      acc_ff, acc_in;
   len_type          len_ff, len_in;

   hex_digit_type    hex;
   logic             is_quote, is_bslash, is_oct, is_lower;
   logic [15:0]      hex_new;
   logic [2:0]       cnt_inc;
   logic             hex_full;
   logic             reprocess;

   logic             flush_en, flush_uni;
   logic [15:0]      flush_val;
   logic [1:0]       fn;
   logic [7:0]       fbyte [MAX_RESULTS];
   logic             tail_en, tail_end;
   logic [7:0]       tail_byte;
   logic [CNT_W-1:0] ndata;

   assign hex       = hex_digit(in_byte);
   assign is_quote  = (in_byte == CH_QUOTE);
   assign is_bslash = (in_byte == CH_BSLASH);
   assign is_oct    = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
   assign is_lower  = (in_byte >= CH_LOW_A) && (in_byte <= CH_LOW_Z);
   assign hex_new   = {acc_ff[11:0], hex.val};
   assign cnt_inc   = cnt_ff + 3'd1;
   assign hex_full  = (mode_ff == MODE_HEX) ? (cnt_inc >= HEX_DIGITS) : (cnt_inc >= UNI_DIGITS);

   // byte goes through normal-mode handling after any pending escape is flushed
   assign reprocess = (mode_ff == MODE_NORMAL)
                   || (((mode_ff == MODE_HEX) || (mode_ff == MODE_UNI)) && !hex.ok)
                   || ((mode_ff == MODE_OCT) && !is_oct);

   // next state
   always_comb begin
      mode_in = MODE_NORMAL;
      cnt_in  = 3'd0;
      acc_in  = 16'd0;
      unique case (mode_ff)
         MODE_NORMAL: begin
         end
         MODE_BSLASH: begin
            if (in_byte == CH_LOW_X) begin
               mode_in = MODE_HEX;
            end else if (in_byte == CH_LOW_U) begin
               mode_in = MODE_UNI;
            end else if (is_oct) begin
               mode_in = MODE_OCT;
               acc_in  = {13'd0, in_byte[2:0]};
            end
         end
         MODE_HEX, MODE_UNI: begin
            if (hex.ok && !hex_full) begin
               mode_in = mode_ff;
               cnt_in  = cnt_inc;
               acc_in  = hex_new;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               mode_in = MODE_OCT;
               acc_in  = {8'd0, acc_ff[4:0], in_byte[2:0]};
            end
         end
         default: begin
         end
      endcase
      if (reprocess && is_bslash) begin
         mode_in = MODE_BSLASH;
      end
   end

   // result words
   always_comb begin
      flush_en  = 1'b0;
      flush_uni = 1'b0;
      flush_val = 16'd0;
      tail_en   = 1'b0;
      tail_end  = 1'b0;
      tail_byte = 8'd0;
      unique case (mode_ff)
         MODE_NORMAL: begin
         end
         MODE_BSLASH: begin
            if (in_byte != CH_LOW_X && in_byte != CH_LOW_U && !is_oct) begin
               tail_en   = 1'b1;
               tail_byte = is_lower ? letter_code(in_byte) : in_byte;
            end
         end
         MODE_HEX, MODE_UNI: begin
            flush_uni = (mode_ff == MODE_UNI);
            if (hex.ok) begin
               flush_en  = hex_full;
               flush_val = hex_new;
            end else begin
               flush_en  = 1'b1;
               flush_val = acc_ff;
            end
         end
         MODE_OCT: begin
            flush_en  = !is_oct;
            flush_val = {8'd0, acc_ff[7:0]};
         end
         default: begin
         end
      endcase
      if (reprocess) begin
         if (is_quote) begin
            tail_en  = 1'b1;
            tail_end = 1'b1;
         end else if (!is_bslash) begin
            tail_en   = 1'b1;
            tail_byte = in_byte;
         end
      end
   end

   // flushed escape value, one byte or UTF-8
   always_comb begin
      fn       = 2'd0;
      fbyte[0] = 8'd0;
      fbyte[1] = 8'd0;
      fbyte[2] = 8'd0;
      fbyte[3] = 8'd0;
      if (flush_en) begin
         if (!flush_uni || flush_val < 16'h0080) begin
            fn       = 2'd1;
            fbyte[0] = flush_val[7:0];
         end else if (flush_val < 16'h0800) begin
            fn       = 2'd2;
            fbyte[0] = {3'b110, flush_val[10:6]};
            fbyte[1] = {2'b10, flush_val[5:0]};
         end else begin
            fn       = 2'd3;
            fbyte[0] = {4'b1110, flush_val[15:12]};
            fbyte[1] = {2'b10, flush_val[11:6]};
            fbyte[2] = {2'b10, flush_val[5:0]};
         end
      end
   end

   assign ndata  = CNT_W'(fn) + CNT_W'(tail_en && !tail_end);
   assign len_in = tail_end ? '0 : sat_len(len_ff, ndata);

   always_comb begin
      set.count = CNT_W'(fn) + CNT_W'(tail_en);
      for (int p = 0; p < MAX_RESULTS; p++) begin
         if (CNT_W'(p) < CNT_W'(fn)) begin
            set.item[p].out_byte = fbyte[p];
            set.item[p].is_end   = 1'b0;
         end else begin
            set.item[p].out_byte = tail_byte;
            set.item[p].is_end   = tail_end;
         end
         // data words count themselves, the end marker does not
         set.item[p].total_len = TOTAL_LEN_W'(sat_len(len_ff,
                                  CNT_W'(p) + CNT_W'(!set.item[p].is_end)));
         set.item[p].last      = (CNT_W'(p + 1) == set.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         cnt_ff  <= 3'd0;
         acc_ff  <= 16'd0;
         len_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         acc_ff  <= acc_in;
         len_ff  <= len_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/csee_out_buf.sv =====
// Result register: holds one input's words, out one per cycle unless out_stall.
`default_nettype none
module csee_out_buf (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_stall,
   input  csee_pkg::res_set_type  set,
   output logic                   out_valid,
   input  wire                    out_stall,
   output csee_pkg::rsp_item_type out_item
);
   import csee_pkg::*;

   rsp_item_type [MAX_RESULTS-1:0] items_ff;
   logic [CNT_W-1:0]               remain_ff;
   logic [IDX_W-1:0]               idx_ff;
   logic                           pop, load, can_load;

   assign out_valid = (remain_ff != '0);
   assign out_item  = items_ff[idx_ff];
   assign pop       = out_valid && !out_stall;
   // refill when empty or while the final word of the previous input leaves
   assign can_load  = (remain_ff == '0) || ((remain_ff == CNT_W'(1)) && !out_stall);
   assign in_stall  = !can_load;
   assign load      = in_valid && can_load;

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= set.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         idx_ff    <= '0;
      end else if (load) begin
         remain_ff <= set.count;
         idx_ff    <= '0;
      end else if (pop) begin
         remain_ff <= remain_ff - CNT_W'(1);
         idx_ff    <= idx_ff + IDX_W'(1);
      end
   end

endmodule
`default_nettype wire
